// File: design/itoa_pkg.sv
// Shared types, constants and the binary-to-BCD step for the integer-to-text core.
package itoa_pkg;

  localparam int ValueW        = 32;
  localparam int DigitN        = 10;
  localparam int BcdW          = 4 * DigitN;
  localparam int StepsPerStage = 4;
  localparam int StageN        = ValueW / StepsPerStage;
  localparam int PosW          = $clog2(DigitN);

  localparam logic [6:0] AsciiZero  = 7'd48;
  localparam logic [6:0] AsciiMinus = 7'd45;

  typedef logic [3:0] digit_t;

  // Item in flight through the conversion pipe
  typedef struct packed {
    logic              neg;
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } conv_t;

  // One shift-and-add-3 step: correct every digit of 5 or more, then shift in one bit
  function automatic conv_t dabble_step(input conv_t c);
    conv_t          o;
    logic [BcdW-1:0] adj;
    adj = c.bcd;
    for (int i = 0; i < DigitN; i++) begin
      if (adj[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
      end
    end
    o.neg = c.neg;
    o.bcd = {adj[BcdW-2:0], c.bin[ValueW-1]};
    o.bin = {c.bin[ValueW-2:0], 1'b0};
    return o;
  endfunction

endpackage

// File: design/itoa_dabble_stage.sv
// One register stage of the conversion pipe: StepsPerStage double-dabble steps.
module itoa_dabble_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  itoa_pkg::conv_t in_data,
  output logic           in_ready,
  output logic           out_valid,
  output itoa_pkg::conv_t out_data,
  input  logic           out_ready
);
  import itoa_pkg::*;

  logic  valid_r;
  conv_t data_r;
  conv_t data_nxt;

  // stage can take a beat when empty or when its content moves on
  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt = in_data;
    for (int s = 0; s < StepsPerStage; s++) begin
      data_nxt = dabble_step(data_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: design/itoa_serialiser.sv
// Takes finished BCD words and sends them out as ASCII, one character per beat.
module itoa_serialiser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  itoa_pkg::conv_t in_data,
  output logic            in_ready,
  output logic            out_valid,
  output logic [6:0]      out_character,
  output logic            out_last_char,
  input  logic            out_stall
);
  import itoa_pkg::*;

  logic            busy_r;
  logic            sign_r;
  logic [PosW-1:0] pos_r;
  digit_t          dig_r [DigitN];
  logic            valid_r;
  logic [6:0]      char_r;
  logic            last_r;

  logic            out_adv;
  logic            final_now;
  logic [PosW-1:0] msd;

  // output register moves when empty or when the receiver takes it
  assign out_adv   = !valid_r || !out_stall;
  assign final_now = busy_r && out_adv && !sign_r && (pos_r == '0);
  assign in_ready  = !busy_r || final_now;

  // most significant non-zero digit; zero gives position 0
  always_comb begin
    msd = '0;
    for (int i = 0; i < DigitN; i++) begin
      if (in_data.bcd[i*4 +: 4] != 4'd0) begin
        msd = PosW'(i);
      end
    end
  end

  // control: sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      sign_r  <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (out_adv) begin
        valid_r <= busy_r;
        if (busy_r) begin
          if (sign_r) begin
            sign_r <= 1'b0;
          end else if (pos_r == '0) begin
            busy_r <= 1'b0;
          end else begin
            pos_r <= pos_r - 1'b1;
          end
        end
      end
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
        sign_r <= in_data.neg;
        pos_r  <= msd;
      end
    end
  end

  // payload: digit store and output character
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < DigitN; i++) begin
        dig_r[i] <= in_data.bcd[i*4 +: 4];
      end
    end
    if (out_adv && busy_r) begin
      char_r <= sign_r ? AsciiMinus : (AsciiZero + {3'b000, dig_r[pos_r]});
      last_r <= !sign_r && (pos_r == '0);
    end
  end

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last_char = last_r;

endmodule

// File: design/signed_int_to_decimal_ascii_core.sv
// Top level: signed 32-bit integer to decimal ASCII text, most significant first.
//
// Input channel: in_valid / in_stall carry one signed integer per beat on in_value.
// Result channel: out_valid / out_stall carry one character per beat on
// out_character, with out_last_char set on the final character of each integer.
// A negative value starts with '-'; zero gives the single character '0'.
// Once its beat is taken, the first character of an integer passes through one
// magnitude stage, eight double-dabble stages of four steps, a load into the
// serialiser and the output register.
// Throughput: one character per cycle on the result side while out_stall is low;
// an integer gives 1 to 11 characters, and the serialiser's single output
// port sets this rate. The conversion pipe takes a new integer every cycle
// unless in_stall is high, and buffers up to nine integers while the serialiser is busy.
// Reset (rst_n low, synchronous) empties the pipe and the serialiser; no state
// is kept between integers. When the receiver stalls, the output character
// holds, the pipe fills up and then in_stall rises; nothing is lost or repeated.
module signed_int_to_decimal_ascii_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [itoa_pkg::ValueW-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [6:0]                  out_character,
  output logic                        out_last_char
);
  import itoa_pkg::*;

  logic  v      [StageN+1];
  conv_t d      [StageN+1];
  logic  rdy    [StageN+2];

  logic  front_valid_r;
  conv_t front_r;
  logic  front_ready;
  logic  in_neg;

  // front stage: sign and magnitude; the most negative value maps onto itself
  assign in_neg      = in_value[ValueW-1];
  assign front_ready = !front_valid_r || rdy[1];
  assign in_stall    = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (front_ready) begin
      front_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready && in_valid) begin
      front_r.neg <= in_neg;
      front_r.bcd <= '0;
      front_r.bin <= in_neg ? (ValueW'(0) - ValueW'(in_value)) : ValueW'(in_value);
    end
  end

  assign v[0]   = front_valid_r;
  assign d[0]   = front_r;
  assign rdy[0] = front_ready;

  // conversion pipe
  for (genvar g = 0; g < StageN; g++) begin : g_stage
    itoa_dabble_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v[g]),
      .in_data  (d[g]),
      .in_ready (rdy[g+1]),
      .out_valid(v[g+1]),
      .out_data (d[g+1]),
      .out_ready(rdy[g+2])
    );
  end

  // character output
  itoa_serialiser u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (v[StageN]),
    .in_data      (d[StageN]),
    .in_ready     (rdy[StageN+1]),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last_char(out_last_char),
    .out_stall    (out_stall)
  );

endmodule
